// ===== rtl/vn_pkg.sv =====
`default_nettype none
package vn_pkg;

  localparam int unsigned COMP_W     = 16;
  localparam int unsigned LSQ_W      = 32;
  localparam int unsigned ROOT_W     = 16;
  // One restoring division step per quotient bit of mag^2 * 2^30 / lsq.
  localparam int unsigned DIV_STAGES = 31;
  // One digit pair of the radicand per stage.
  localparam int unsigned SQRT_STAGES = 16;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
  } vn_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] unit_x;
    logic signed [COMP_W-1:0] unit_y;
    logic signed [COMP_W-1:0] unit_z;
    logic [LSQ_W-1:0]         length_sq;
    logic [ROOT_W-1:0]        length_root;
    logic                     is_zero;
  } vn_out_t;

endpackage
`default_nettype wire

// ===== rtl/vn_isqrt_pipe.sv =====
`default_nettype none
module vn_isqrt_pipe import vn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [31:0]       radicand,
  output logic      [ROOT_W-1:0] root
);

  logic [31:0] rem_r [SQRT_STAGES];
  logic [31:0] res_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [31:0] BitVal = 32'(1) << (30 - 2 * k);
    logic [31:0] rem_in;
    logic [31:0] res_in;
    logic [31:0] trial;
    logic [31:0] rem_nxt;
    logic [31:0] res_nxt;

    assign rem_in = (k == 0) ? radicand : rem_r[(k == 0) ? 0 : k - 1];
    assign res_in = (k == 0) ? 32'd0 : res_r[(k == 0) ? 0 : k - 1];
    assign trial  = res_in + BitVal;

    always_comb begin
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BitVal;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/vn_div_pipe.sv =====
`default_nettype none
module vn_div_pipe import vn_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [31:0]           num,
  input  wire logic [31:0]           den,
  output logic      [DIV_STAGES-1:0] quot
);

  // The dividend is num * 2^30; num never exceeds den, so the partial
  // remainder stays below den and fits 32 bits.
  logic [31:0]           rem_r [DIV_STAGES];
  logic [31:0]           den_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0]           part;
    logic [31:0]           den_in;
    logic [DIV_STAGES-1:0] quo_in;
    logic                  ge;
    logic [31:0]           rem_nxt;

    assign part   = (k == 0) ? {1'b0, num} : {rem_r[(k == 0) ? 0 : k - 1], 1'b0};
    assign den_in = (k == 0) ? den : den_r[(k == 0) ? 0 : k - 1];
    assign quo_in = (k == 0) ? '0 : quo_r[(k == 0) ? 0 : k - 1];
    assign ge     = part >= {1'b0, den_in};
    assign rem_nxt = ge ? 32'(part - {1'b0, den_in}) : part[31:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= {quo_in[DIV_STAGES-2:0], ge};
      end
    end
  end

  assign quot = quo_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/vector3_normalize_core.sv =====
`default_nettype none
// Normalizes one signed 16-bit 3-vector per clock while in_stall is low.
// A result passes the squares and sum registers, the per-component
// restoring divider (one quotient bit a stage), the square root that turns
// the quotient into the rounded Q1.14 component, and one output register.
// The length root is computed alongside. The block stalls its input
// only once a result is held in the output skid stage.
// zero_threshold may be written only while no beat is in flight.
module vector3_normalize_core import vn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire vn_in_t      in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output vn_out_t          out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned TailDepth = DIV_STAGES + SQRT_STAGES;
  localparam int unsigned RootDelay = DIV_STAGES;

  typedef struct packed {
    logic             sign_x;
    logic             sign_y;
    logic             sign_z;
    logic             kill;
    logic             is_zero;
    logic [LSQ_W-1:0] lsq;
  } side_t;

  logic        en;
  logic [31:0] threshold_r;

  // Squares.
  logic        s1_valid_r;
  logic [31:0] sq_x_r, sq_y_r, sq_z_r;
  logic [2:0]  s1_sign_r;
  logic [15:0] mag_x, mag_y, mag_z;

  // Sum and threshold.
  logic        s2_valid_r;
  logic [31:0] s2_sq_x_r, s2_sq_y_r, s2_sq_z_r;
  side_t       s2_side_r;
  logic [31:0] lsq_nxt;

  logic        vline_r [TailDepth];
  side_t       side_r  [TailDepth];
  logic [ROOT_W-1:0] rootd_r [RootDelay];

  logic [DIV_STAGES-1:0] q_x, q_y, q_z;
  logic [ROOT_W-1:0]     root_len, m_x, m_y, m_z;

  logic    out_valid_r, skid_valid_r;
  vn_out_t out_data_r, skid_data_r, item;
  logic    push, take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  assign mag_x = in_data.comp_x[15] ? 16'(~in_data.comp_x + 16'd1) : in_data.comp_x;
  assign mag_y = in_data.comp_y[15] ? 16'(~in_data.comp_y + 16'd1) : in_data.comp_y;
  assign mag_z = in_data.comp_z[15] ? 16'(~in_data.comp_z + 16'd1) : in_data.comp_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r    <= mag_x * mag_x;
      sq_y_r    <= mag_y * mag_y;
      sq_z_r    <= mag_z * mag_z;
      s1_sign_r <= {in_data.comp_x[15], in_data.comp_y[15], in_data.comp_z[15]};
    end
  end

  assign lsq_nxt = sq_x_r + sq_y_r + sq_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq_x_r         <= sq_x_r;
      s2_sq_y_r         <= sq_y_r;
      s2_sq_z_r         <= sq_z_r;
      s2_side_r.sign_x  <= s1_sign_r[2];
      s2_side_r.sign_y  <= s1_sign_r[1];
      s2_side_r.sign_z  <= s1_sign_r[0];
      s2_side_r.is_zero <= lsq_nxt < threshold_r;
      s2_side_r.kill    <= (lsq_nxt < threshold_r) || (lsq_nxt == 32'd0);
      s2_side_r.lsq     <= lsq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int i = 0; i < TailDepth; i++) begin
        vline_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      vline_r[0] <= s2_valid_r;
      for (int i = 1; i < TailDepth; i++) begin
        vline_r[i] <= vline_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s2_side_r;
      for (int i = 1; i < TailDepth; i++) begin
        side_r[i] <= side_r[i-1];
      end
      rootd_r[0] <= root_len;
      for (int i = 1; i < RootDelay; i++) begin
        rootd_r[i] <= rootd_r[i-1];
      end
    end
  end

  vn_isqrt_pipe u_len_root (
    .clk(clk), .en(en), .radicand(s2_side_r.lsq), .root(root_len)
  );

  vn_div_pipe u_div_x (.clk(clk), .en(en), .num(s2_sq_x_r), .den(s2_side_r.lsq), .quot(q_x));
  vn_div_pipe u_div_y (.clk(clk), .en(en), .num(s2_sq_y_r), .den(s2_side_r.lsq), .quot(q_y));
  vn_div_pipe u_div_z (.clk(clk), .en(en), .num(s2_sq_z_r), .den(s2_side_r.lsq), .quot(q_z));

  // floor(sqrt(floor(mag^2 * 2^30 / lsq))) is the largest m with
  // m^2 * lsq <= mag^2 * 2^30; rounding to nearest then is (m + 1) / 2.
  vn_isqrt_pipe u_unit_x (.clk(clk), .en(en), .radicand({1'b0, q_x}), .root(m_x));
  vn_isqrt_pipe u_unit_y (.clk(clk), .en(en), .radicand({1'b0, q_y}), .root(m_y));
  vn_isqrt_pipe u_unit_z (.clk(clk), .en(en), .radicand({1'b0, q_z}), .root(m_z));

  function automatic logic signed [COMP_W-1:0] unit_of(input logic [ROOT_W-1:0] m,
                                                      input logic sign, input logic kill);
    logic [COMP_W-1:0] n;
    n = COMP_W'(({1'b0, m} + 17'd1) >> 1);
    if (kill) begin
      return '0;
    end
    return sign ? COMP_W'(~n + 16'd1) : n;
  endfunction

  always_comb begin
    item.unit_x      = unit_of(m_x, side_r[TailDepth-1].sign_x, side_r[TailDepth-1].kill);
    item.unit_y      = unit_of(m_y, side_r[TailDepth-1].sign_y, side_r[TailDepth-1].kill);
    item.unit_z      = unit_of(m_z, side_r[TailDepth-1].sign_z, side_r[TailDepth-1].kill);
    item.length_sq   = side_r[TailDepth-1].lsq;
    item.length_root = rootd_r[RootDelay-1];
    item.is_zero     = side_r[TailDepth-1].is_zero;
  end

  assign push = en && vline_r[TailDepth-1];
  assign take = out_valid_r && !out_stall;

  // A beat that finds the output register occupied parks in the skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_r <= item;
      end else begin
        skid_data_r <= item;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
